>>> hdl/fnv_pkg.sv
// Shared constants and helpers for the FNV-1a case-folding hash engine.
// No dependencies.
`timescale 1ns / 1ps

package fnv_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [HashW-1:0] BASIS32 = 64'h0000_0000_811C_9DC5;
  localparam logic [HashW-1:0] BASIS64 = 64'hCBF2_9CE4_8422_2325;

  localparam logic [ByteW-1:0] UPPER_A  = 8'h41;
  localparam logic [ByteW-1:0] UPPER_Z  = 8'h5A;
  localparam logic [ByteW-1:0] CASE_GAP = 8'h20;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_WIDE_MODE = 1'b0;
  localparam reg_idx_t REG_FOLD_CASE = 1'b1;

  // x * 0x01000193 mod 2^32
  function automatic logic [HalfW-1:0] mul_prime32(input logic [HalfW-1:0] x);
    logic [HalfW-1:0] acc;
    acc = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    return acc;
  endfunction

  // x * 0x100000001B3 mod 2^64
  function automatic logic [HashW-1:0] mul_prime64(input logic [HashW-1:0] x);
    logic [HashW-1:0] acc;
    acc = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    return acc;
  endfunction

  function automatic logic [HashW-1:0] basis_of(input logic wide);
    return wide ? BASIS64 : BASIS32;
  endfunction

endpackage

>>> hdl/fnv1a_hash_case_fold.sv
// FNV-1a hash engine, 32/64-bit, with optional ASCII lower-case folding.
// Depends on fnv_pkg.
`timescale 1ns / 1ps

// Takes one key byte per cycle unless in_tready drops: it does so while
// a key's last byte waits in s1 and out_tdata holds an untaken hash.
// The last byte is registered in s1, its hash then in out_d_r. XOR with
// the byte and a constant multiply by the FNV prime, a short shift-add,
// form a combinational accumulator loop. Zero bytes are skipped; the byte
// marked with in_tlast closes the key, emits the hash on out_tdata and
// reloads the offset basis. Writing wide_mode reloads the basis of the
// new width; fold_case applies from the next byte. Write configuration
// only while no key is in flight.
module fnv1a_hash_case_fold
  import fnv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                 in_tlast,   // last_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [HashW-1:0]     out_tdata,  // [63:0] hash_value
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  reg_idx_t             cfg_index,
  input  logic                 cfg_data
);

  logic             wide_r, wide_nxt;
  logic             fold_r, fold_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;
  logic [HashW-1:0] acc_r, acc_nxt;
  logic             out_v_r, out_v_nxt;
  logic [HashW-1:0] out_d_r;

  logic             in_go, s1_go, cfg_go;
  logic [ByteW-1:0] fbyte;
  logic [HashW-1:0] mix, hash;
  logic [HalfW-1:0] mix32;

  assign cfg_ready = 1'b1;
  assign cfg_go    = cfg_valid & cfg_ready;

  assign s1_go     = s1_v_r & (~s1_last_r | ~out_v_r | out_tready);
  assign in_tready = ~s1_v_r | s1_go;
  assign in_go     = in_tvalid & in_tready;

  always_comb begin
    fbyte = s1_byte_r;
    if (fold_r && (s1_byte_r inside {[UPPER_A:UPPER_Z]})) begin
      fbyte = s1_byte_r + CASE_GAP;
    end
  end

  always_comb begin
    mix   = acc_r ^ {{(HashW-ByteW){1'b0}}, fbyte};
    mix32 = mix[HalfW-1:0];
    if (s1_byte_r == '0) begin
      hash = acc_r;
    end else if (wide_r) begin
      hash = mul_prime64(mix);
    end else begin
      hash = {{(HashW-HalfW){1'b0}}, mul_prime32(mix32)};
    end
  end

  always_comb begin
    wide_nxt = wide_r;
    fold_nxt = fold_r;
    acc_nxt  = acc_r;
    if (s1_go) begin
      acc_nxt = s1_last_r ? basis_of(wide_r) : hash;
    end
    if (cfg_go) begin
      case (cfg_index)
        REG_WIDE_MODE: begin
          wide_nxt = cfg_data;
          acc_nxt  = basis_of(cfg_data);
        end
        REG_FOLD_CASE: fold_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_go) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_go && s1_last_r) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r  <= 1'b0;
      fold_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= BASIS32;
    end else begin
      wide_r  <= wide_nxt;
      fold_r  <= fold_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go && s1_last_r) begin
      out_d_r <= hash;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_narrow_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !wide_r |-> acc_r[HashW-1:HalfW] == '0)
    else $error("upper accumulator bits set in 32-bit mode");

  a_mode_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_go && cfg_index == REG_WIDE_MODE |=> acc_r == basis_of(wide_r))
    else $error("accumulator not reloaded after mode write");

  a_key_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> out_v_r && acc_r == basis_of(wide_r))
    else $error("key end did not emit hash and reload basis");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && s1_v_r && s1_last_r |-> !s1_go)
    else $error("pending hash overwritten");

endmodule
